### src/sfir_pkg.sv
// Shared widths, register indexes and the cell link type of the strided FIR filter.
`default_nettype none

package sfir_pkg;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int ACC_W      = 16;
  localparam int PROD_W     = PIX_W + COEF_W;
  localparam int NUM_COEF   = 16;
  localparam int TAP_CNT_W  = 5;
  localparam int SPACING_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Parameter defaults for the top level
  localparam int MAX_TAPS_DEF    = 16;
  localparam int MAX_SPACING_DEF = 2048;
  localparam int DELAY_DEPTH_DEF = 32768;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_SPACING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_3      = 3'd5;

  // Partial sum handed from one cell to the next
  typedef struct packed {
    logic             vld;
    logic [ACC_W-1:0] acc;
  } link_t;

endpackage

`default_nettype wire

### src/sfir_if.sv
// Handshake channel interfaces: pixel input, filtered pixel output, register writes.
`default_nettype none

interface sfir_pix_in_if
  import sfir_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface sfir_pix_out_if
  import sfir_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

interface sfir_cfg_if
  import sfir_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

### src/strided_fir_q16_pixels_core.sv
// Top level of the strided FIR pixel filter: config, delay store, tap sequencer, cell chain.
//
// Usage:
//  - in_chan carries one 8-bit pixel per transfer in raster order; out_chan carries one
//    filtered pixel for every input pixel once the window of (taps-1)*spacing+1 pixels
//    is full; earlier pixels give no result.
//  - cfg_chan writes registers: 0 tap count, 1 tap spacing, 2..5 four Q16 coefficients
//    each. cfg_chan.ready is always high. After a tap count or spacing write the input
//    is held off while the address offsets are reduced modulo the store depth by two
//    three-step reciprocal remainder units.
//  - A pixel that gives no result leaves the input ready for the next pixel. For a pixel
//    that gives a result, the tap sequencer reads one tap per cycle from the single
//    read port of the delay store, and the partial sum walks the row of MAX_TAPS cells,
//    one cell per cycle. The input is held off until the result is moved to the output
//    register; the next pixel can be taken once the result has moved there.
//  - When the receiver stalls, the result waits in the output register; one more result
//    can be computed and then waits in a holding register until the output frees up.
//  - Reset (rst_n low, synchronous) restores tap count 1, spacing 1, zero coefficients
//    and an empty window. The delay store is not cleared: an entry is read only after
//    it has been written.
`default_nettype none

module strided_fir_q16_pixels_core
  import sfir_pkg::*;
#(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int MAX_SPACING = MAX_SPACING_DEF,
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  sfir_pix_in_if.sink     in_chan,
  sfir_pix_out_if.source  out_chan,
  sfir_cfg_if.sink        cfg_chan
);

  localparam int TAP_W  = $clog2(MAX_TAPS + 1);
  localparam int SP_W   = $clog2(MAX_SPACING + 1);
  localparam int SPAN_W = $clog2((MAX_TAPS - 1) * MAX_SPACING + 2);
  localparam int AW     = $clog2(DELAY_DEPTH);
  localparam logic [AW:0] DEPTH_X = (AW + 1)'(DELAY_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_PUSH  = 4'b1000
  } state_t;

  // Clamp a signed 16-bit sum to a pixel
  function automatic logic [PIX_W-1:0] clamp_pix(input logic [ACC_W-1:0] s);
    logic [PIX_W-1:0] r;
    if (s[ACC_W-1]) begin
      r = '0;
    end else if (s > ACC_W'(255)) begin
      r = '1;
    end else begin
      r = s[PIX_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [TAP_CNT_W-1:0] tap_count_r;
  logic [SPACING_W-1:0] tap_spacing_r;
  logic [COEF_W-1:0]    coef_r [NUM_COEF];
  logic                 cfg_xfer;
  logic [1:0]           coef_grp;

  // Derived window geometry
  logic [TAP_W-1:0]  taps_eff_c;
  logic [SP_W-1:0]   sp_eff_c;
  logic [SPAN_W-1:0] back_c;
  logic [TAP_W-1:0]  taps_r;
  logic [SPAN_W-1:0] span_r;
  logic [SPAN_W-1:0] back_r;
  logic [SP_W-1:0]   sp_r;
  logic              setup_r;
  logic              load_r;
  logic [AW-1:0]     back_mod;
  logic [AW-1:0]     sp_mod;
  logic              back_busy;
  logic              sp_busy;
  logic              cfg_busy;

  // Input side and sequencer
  state_t            st_r, st_nxt;
  logic              in_xfer;
  logic              in_ready_c;
  logic [AW-1:0]     wp_r;
  logic [SPAN_W-1:0] fill_r;
  logic [SPAN_W-1:0] fill_clamp;
  logic [SPAN_W-1:0] fill_nxt;
  logic              hit;
  logic [AW:0]       a0_diff;
  logic [AW-1:0]     a0;
  logic [AW:0]       step_sum;
  logic [AW-1:0]     addr_nxt;
  logic [AW-1:0]     addr_r;
  logic [TAP_W-1:0]  k_r;
  logic              rd_en;
  logic [PIX_W-1:0]  rd_pix;
  logic              feed_first_r;
  logic              feed_tap_r;
  logic [PIX_W-1:0]  bus_pix;

  // Cell chain and output
  link_t             chain [MAX_TAPS+1];
  logic [MAX_TAPS-1:0] chain_vld;
  logic              tail_vld;
  logic [PIX_W-1:0]  pend_r;
  logic              slot_free;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_data_r;

  // ---------------------------------------------------------------- config port
  assign cfg_chan.ready = 1'b1;
  assign cfg_xfer       = cfg_chan.valid && cfg_chan.ready;
  assign coef_grp       = 2'(cfg_chan.reg_index - REG_COEF_0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r   <= TAP_CNT_W'(1);
      tap_spacing_r <= SPACING_W'(1);
      for (int c = 0; c < NUM_COEF; c++) begin
        coef_r[c] <= '0;
      end
    end else if (cfg_xfer) begin
      case (cfg_chan.reg_index)
        REG_TAP_COUNT: begin
          tap_count_r <= cfg_chan.wr_data[TAP_CNT_W-1:0];
        end
        REG_TAP_SPACING: begin
          tap_spacing_r <= cfg_chan.wr_data[SPACING_W-1:0];
        end
        REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3: begin
          for (int c = 0; c < NUM_COEF; c++) begin
            if (coef_grp == 2'(c >> 2)) begin
              coef_r[c] <= cfg_chan.wr_data[(c & 3) * COEF_W +: COEF_W];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Effective tap count and spacing, clamped to the supported range
  always_comb begin
    taps_eff_c = TAP_W'(tap_count_r);
    if (tap_count_r == '0) begin
      taps_eff_c = TAP_W'(1);
    end else if (tap_count_r > TAP_CNT_W'(MAX_TAPS)) begin
      taps_eff_c = TAP_W'(MAX_TAPS);
    end
    sp_eff_c = SP_W'(tap_spacing_r);
    if (tap_spacing_r == '0) begin
      sp_eff_c = SP_W'(1);
    end else if (tap_spacing_r > SPACING_W'(MAX_SPACING)) begin
      sp_eff_c = SP_W'(MAX_SPACING);
    end
  end

  assign back_c = SPAN_W'(SPAN_W'(taps_eff_c - TAP_W'(1)) * SPAN_W'(sp_eff_c));

  // Geometry update: register the product, then reduce modulo the depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r <= 1'b0;
      load_r  <= 1'b0;
      taps_r  <= TAP_W'(1);
      span_r  <= SPAN_W'(1);
    end else begin
      setup_r <= cfg_xfer && ((cfg_chan.reg_index == REG_TAP_COUNT) ||
                              (cfg_chan.reg_index == REG_TAP_SPACING));
      load_r  <= setup_r;
      if (setup_r) begin
        taps_r <= taps_eff_c;
        span_r <= back_c + SPAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (setup_r) begin
      back_r <= back_c;
      sp_r   <= sp_eff_c;
    end
  end

  sfir_rem #(
    .DW       (SPAN_W),
    .DIVISOR  (DELAY_DEPTH),
    .INIT_REM (0)
  ) u_back_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (load_r),
    .dividend (back_r),
    .rem      (back_mod),
    .busy     (back_busy)
  );

  sfir_rem #(
    .DW       (SP_W),
    .DIVISOR  (DELAY_DEPTH),
    .INIT_REM (1)
  ) u_sp_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (load_r),
    .dividend (sp_r),
    .rem      (sp_mod),
    .busy     (sp_busy)
  );

  assign cfg_busy = setup_r || load_r || back_busy || sp_busy;

  // ---------------------------------------------------------------- input side
  assign in_ready_c    = (st_r == ST_IDLE) && !cfg_busy;
  assign in_chan.ready = in_ready_c;
  assign in_xfer       = in_chan.valid && in_ready_c;

  // Fill count: clamp to the current span, then count up to it
  assign fill_clamp = (fill_r > span_r) ? span_r : fill_r;
  assign fill_nxt   = (fill_clamp < span_r) ? fill_clamp + SPAN_W'(1) : fill_clamp;
  assign hit        = (fill_nxt == span_r);

  // Oldest tap address and the step to the next tap, both modulo the depth
  assign a0_diff  = {1'b0, wp_r} - {1'b0, back_mod};
  assign a0       = a0_diff[AW] ? AW'(a0_diff + DEPTH_X) : AW'(a0_diff);
  assign step_sum = {1'b0, addr_r} + {1'b0, sp_mod};
  assign addr_nxt = (step_sum >= DEPTH_X) ? AW'(step_sum - DEPTH_X) : AW'(step_sum);

  assign rd_en = (st_r == ST_ISSUE) && (k_r < taps_r);

  sfir_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DELAY_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (wp_r),
    .wdata (in_chan.pixel_in),
    .re    (rd_en),
    .raddr (addr_r),
    .rdata (rd_pix)
  );

  // Sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_xfer && hit) begin
          st_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_r == TAP_W'(MAX_TAPS - 1)) begin
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tail_vld) begin
          st_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      wp_r         <= '0;
      fill_r       <= '0;
      feed_first_r <= 1'b0;
      feed_tap_r   <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      feed_first_r <= (st_r == ST_ISSUE) && (k_r == '0);
      feed_tap_r   <= rd_en;
      if (in_xfer) begin
        fill_r <= fill_nxt;
        wp_r   <= (wp_r == AW'(DELAY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
    end
  end

  // Tap counter and read address
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      k_r    <= '0;
      addr_r <= a0;
    end else if (st_r == ST_ISSUE) begin
      k_r    <= k_r + TAP_W'(1);
      addr_r <= addr_nxt;
    end
  end

  // ---------------------------------------------------------------- cell chain
  assign bus_pix = feed_tap_r ? rd_pix : '0;

  always_comb begin
    chain[0].vld = feed_first_r;
    chain[0].acc = '0;
  end

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    sfir_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .prev  (chain[i]),
      .pixel (bus_pix),
      .coef  (coef_r[i]),
      .nxt   (chain[i+1])
    );
    assign chain_vld[i] = chain[i+1].vld;
  end

  assign tail_vld = chain[MAX_TAPS].vld;

  // ---------------------------------------------------------------- output side
  assign slot_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if ((st_r == ST_DRAIN) && tail_vld) begin
      pend_r <= clamp_pix(chain[MAX_TAPS].acc);
    end
    if ((st_r == ST_PUSH) && slot_free) begin
      out_data_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((st_r == ST_PUSH) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pixel_out = out_data_r;

`ifndef NO_ASSERTIONS
  // Only one partial sum is ever in flight along the chain
  a_one_wavefront: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld))
    else $error("more than one partial sum in the cell chain");

  // The finished sum leaves the chain only while the sequencer waits for it
  a_tail_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    tail_vld |-> (st_r == ST_DRAIN))
    else $error("chain result outside of drain");

  // Tap addresses stay inside the delay store
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ISSUE) |-> ({1'b0, addr_r} < DEPTH_X))
    else $error("tap address beyond the delay store");

  // A pushed result shows up on the output with the held value
  a_push_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_PUSH) && slot_free) |=> (out_valid_r && (out_data_r == $past(pend_r))))
    else $error("held result not moved to the output register");
`endif

endmodule

`default_nettype wire

### src/sfir_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module sfir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/sfir_rem.sv
// Remainder unit: dividend mod a constant divisor by reciprocal multiply and one correction.
`default_nettype none

module sfir_rem #(
  parameter int DW       = 15,
  parameter int DIVISOR  = 32768,
  parameter int INIT_REM = 0,
  localparam int RW      = $clog2(DIVISOR)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  output logic      [RW-1:0] rem,
  output logic               busy
);

  // Quotient estimate floor(x * floor(2^DW / DIVISOR) / 2^DW) is exact or one short
  localparam int XW = ((DW > RW) ? DW : RW) + 1;
  localparam int PW = 2 * DW + 1;
  localparam logic [DW:0]   RECIP = (DW + 1)'((1 << DW) / DIVISOR);
  localparam logic [XW-1:0] DIV_X = XW'(DIVISOR);

  logic [2:0]    phase_r;
  logic [DW-1:0] dv_r;
  logic [PW-1:0] qprod;
  logic [DW-1:0] quo_r;
  logic [XW-1:0] back_prod;
  logic [XW-1:0] part_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] rem_nxt;

  assign qprod     = PW'(dv_r) * PW'(RECIP);
  assign back_prod = XW'(quo_r) * DIV_X;
  // Partial remainder is below twice the divisor: one subtract finishes it
  assign rem_nxt   = (part_r >= DIV_X) ? RW'(part_r - DIV_X) : RW'(part_r);

  // Three steps after start: estimate, multiply back, correct
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      rem_r   <= RW'(INIT_REM);
    end else if (start) begin
      phase_r <= 3'b001;
    end else begin
      phase_r <= {phase_r[1:0], 1'b0};
      if (phase_r[2]) begin
        rem_r <= rem_nxt;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      dv_r <= dividend;
    end
    if (phase_r[0]) begin
      quo_r <= qprod[2*DW-1:DW];
    end
    if (phase_r[1]) begin
      part_r <= XW'(dv_r) - back_prod;
    end
  end

  assign rem  = rem_r;
  assign busy = (phase_r != '0);

endmodule

`default_nettype wire

### src/sfir_cell.sv
// One tap cell: adds the high byte of pixel times coefficient to the passing sum.
`default_nettype none

module sfir_cell
  import sfir_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire link_t             prev,
  input  wire logic [PIX_W-1:0]  pixel,
  input  wire logic [COEF_W-1:0] coef,
  output link_t                  nxt
);

  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  term;
  logic              vld_r;
  logic [ACC_W-1:0]  acc_r;

  // Q16 product, keep only the integer part
  assign prod = PROD_W'(pixel) * PROD_W'(coef);
  assign term = prod[PROD_W-1 -: PIX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= prev.vld;
    end
  end

  // Sum wraps at ACC_W bits
  always_ff @(posedge clk) begin
    if (prev.vld) begin
      acc_r <= prev.acc + {{(ACC_W-PIX_W){1'b0}}, term};
    end
  end

  always_comb begin
    nxt.vld = vld_r;
    nxt.acc = acc_r;
  end

endmodule

`default_nettype wire
